// ===== hw/rtl/otmu_pkg.sv =====
// Shared constants and types for the optical transfer multiply block.
// Used by the top level, the square-root pipeline and the sine/cosine pipeline.
// No dependencies.
package otmu_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_MODE     = 2'd0,
    CFG_FREQ_SQ  = 2'd1,
    CFG_PHASE    = 2'd2,
    CFG_FRESNEL  = 2'd3
  } cfg_reg_t;

  // Transfer modes
  localparam logic MODE_ANGULAR = 1'b0;
  localparam logic MODE_FRESNEL = 1'b1;

  // Fixed field widths
  localparam int IDX_W   = 10;  // row / column index
  localparam int FREQ_W  = 12;  // signed frequency index
  localparam int N2_W    = 22;  // squared radius
  localparam int ARG_W   = 41;  // angular argument, Q0.40 up to 1.0
  localparam int RAD_W   = 61;  // radicand, argument << 20
  localparam int ROOT_W  = 31;  // root, Q1.30
  localparam int PHASE_W = 32;  // phase in turns, Q0.32
  localparam int X_W     = 30;  // octant angle in radians, Q0.30
  localparam int CS_W    = 31;  // cosine / sine magnitude, Q1.30

  // 2*pi in Q32
  localparam logic [34:0] TWO_PI_Q32 = 35'd26986075409;
  // 1.0 in Q1.30
  localparam logic [CS_W-1:0] ONE_Q30 = 31'h4000_0000;

  // Pipeline depths of the shared units
  localparam int SQRT_LAT = 16;
  localparam int TRIG_LAT = 12;

endpackage

// ===== hw/rtl/otmu_sqrt.sv =====
// Pipelined integer square root, two result bits per stage.
// Depends on otmu_pkg for widths and depth.
module otmu_sqrt (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            vld_i,
  input  logic [otmu_pkg::RAD_W-1:0]      rad_i,
  output logic                            vld_o,
  output logic [otmu_pkg::ROOT_W-1:0]     root_o
);

  localparam int NS = otmu_pkg::SQRT_LAT;

  typedef struct packed {
    logic [otmu_pkg::RAD_W-1:0] rem;
    logic [62:0]                res;
  } sq_t;

  // One digit step of the bitwise root; bpos selects the trial bit 4^bpos
  function automatic sq_t sq_step(input sq_t cur, input int unsigned bpos);
    sq_t         nxt;
    logic [63:0] bitv;
    logic [63:0] trial;
    bitv  = 64'd1 << (2 * bpos);
    trial = {1'b0, cur.res} + bitv;
    if ({3'd0, cur.rem} >= trial) begin
      nxt.rem = otmu_pkg::RAD_W'({3'd0, cur.rem} - trial);
      nxt.res = 63'(({1'b0, cur.res} >> 1) + bitv);
    end else begin
      nxt.rem = cur.rem;
      nxt.res = cur.res >> 1;
    end
    return nxt;
  endfunction

  sq_t         st_r [NS];
  logic [NS-1:0] vld_r;

  // Valid bits travel with the stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NS-2:0], vld_i};
    end
  end

  for (genvar g = 0; g < NS; g++) begin : g_stage
    sq_t st_in;
    sq_t st_a;
    sq_t st_b;
    if (g == 0) begin : g_first
      assign st_in = '{rem: rad_i, res: 63'd0};
    end else begin : g_next
      assign st_in = st_r[g-1];
    end
    always_comb begin
      st_a = sq_step(st_in, 31 - 2 * g);
      st_b = sq_step(st_a, 30 - 2 * g);
    end
    always_ff @(posedge clk) begin
      st_r[g] <= st_b;
    end
  end

  assign vld_o  = vld_r[NS-1];
  assign root_o = st_r[NS-1].res[otmu_pkg::ROOT_W-1:0];

  // Root of a 61-bit radicand never reaches the upper result bits
  a_root_fits: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NS-1] |-> st_r[NS-1].res[62:otmu_pkg::ROOT_W] == '0)
    else $error("square root exceeds result width");

endmodule

// ===== hw/rtl/otmu_trig.sv =====
// Pipelined sine and cosine of an octant angle by truncated Horner series.
// Depends on otmu_pkg for widths, constants and depth.
module otmu_trig (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          vld_i,
  input  logic [otmu_pkg::X_W-1:0]      x_i,
  output logic                          vld_o,
  output logic [otmu_pkg::CS_W-1:0]     cos_o,
  output logic [otmu_pkg::CS_W-1:0]     sin_o
);

  localparam int NS = otmu_pkg::TRIG_LAT;
  localparam int unsigned COS_DIV [6] = '{132, 90, 56, 30, 12, 2};
  localparam int unsigned SIN_DIV [5] = '{110, 72, 42, 20, 6};
  localparam logic [otmu_pkg::CS_W-1:0] ONE = otmu_pkg::ONE_Q30;

  logic [otmu_pkg::X_W-1:0]  x_r  [10];
  logic [otmu_pkg::X_W-1:0]  x2_r [10];
  logic [otmu_pkg::CS_W-1:0] cv_r [NS];
  logic [otmu_pkg::CS_W-1:0] sv_r [NS];
  logic [NS-1:0]             vld_r;
  logic [59:0]               xsq;

  assign xsq = {30'd0, x_i} * {30'd0, x_i};

  // Valid bits and the angle lines
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NS-2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    x_r[0]  <= x_i;
    x2_r[0] <= xsq[59:30];
    cv_r[0] <= {1'b0, xsq[59:30]};
    sv_r[0] <= {1'b0, xsq[59:30]};
    for (int i = 1; i < 10; i++) begin
      x_r[i]  <= x_r[i-1];
      x2_r[i] <= x2_r[i-1];
    end
  end

  // Odd stages: t = 1 - u / K by reciprocal multiply (the sine holds in the last one); even stages: u = x2 * t
  for (genvar k = 1; k < NS; k++) begin : g_stage
    if (k % 2 == 1) begin : g_div
      localparam int unsigned CK   = COS_DIV[(k-1)/2];
      localparam int unsigned CSH  = 31 + $clog2(CK);
      localparam logic [63:0] CRCP = ((64'd1 << CSH) + 64'(CK) - 64'd1) / CK;
      logic [63:0] cprod;
      logic [63:0] cquo;
      assign cprod = {33'd0, cv_r[k-1]} * CRCP;
      assign cquo  = cprod >> CSH;
      always_ff @(posedge clk) begin
        cv_r[k] <= ONE - cquo[otmu_pkg::CS_W-1:0];
      end
      if (k <= 9) begin : g_sdiv
        localparam int unsigned SK   = SIN_DIV[(k-1)/2];
        localparam int unsigned SSH  = 31 + $clog2(SK);
        localparam logic [63:0] SRCP = ((64'd1 << SSH) + 64'(SK) - 64'd1) / SK;
        logic [63:0] sprod;
        logic [63:0] squo;
        assign sprod = {33'd0, sv_r[k-1]} * SRCP;
        assign squo  = sprod >> SSH;
        always_ff @(posedge clk) begin
          sv_r[k] <= ONE - squo[otmu_pkg::CS_W-1:0];
        end
      end else begin : g_shold
        always_ff @(posedge clk) begin
          sv_r[k] <= sv_r[k-1];
        end
      end
    end else begin : g_mul
      logic [60:0] cprod;
      logic [60:0] sprod;
      assign cprod = {31'd0, x2_r[k-1]} * {30'd0, cv_r[k-1]};
      // last sine stage multiplies by x instead of x squared
      if (k == 10) begin : g_sx
        assign sprod = {31'd0, x_r[k-1]} * {30'd0, sv_r[k-1]};
      end else begin : g_sx2
        assign sprod = {31'd0, x2_r[k-1]} * {30'd0, sv_r[k-1]};
      end
      always_ff @(posedge clk) begin
        cv_r[k] <= cprod[60:30];
        sv_r[k] <= sprod[60:30];
      end
    end
  end

  assign vld_o = vld_r[NS-1];
  assign cos_o = cv_r[NS-1];
  assign sin_o = sv_r[NS-1];

  // Over one octant the cosine stays between one half and one
  a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NS-1] |-> (cv_r[NS-1] >= 31'h2000_0000) && (cv_r[NS-1] <= ONE))
    else $error("cosine out of octant range");

endmodule

// ===== hw/rtl/optical_transfer_multiply_unit.sv =====
// Top level: multiplies one spectrum bin by the propagation transfer function.
// Depends on otmu_pkg, otmu_sqrt and otmu_trig.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-------------------------------
//  input   | in_row_index in_col_index in_spec_re/im | taken when start && !busy
//  result  | out_re out_im out_evanescent            | out_valid for one cycle
//  config  | cfg_index cfg_wdata                     | written when cfg_we
//
// An item can enter every cycle while busy is low; its result passes through the
// 16-stage root pipeline and the 12-stage sine/cosine pipeline plus 12 more
// stages of index mapping, scaling, phase and rotation.
// busy is high only in the cycle after a reset cycle; the synchronous reset
// clears all valid bits and the configuration registers. Results cannot be held off.
module optical_transfer_multiply_unit #(
  parameter int GRID_SIZE   = 1024,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [62:0]                   cfg_wdata,
  input  logic                          start,
  output logic                          busy,
  input  logic [otmu_pkg::IDX_W-1:0]    in_row_index,
  input  logic [otmu_pkg::IDX_W-1:0]    in_col_index,
  input  logic signed [SAMPLE_BITS-1:0] in_spec_re,
  input  logic signed [SAMPLE_BITS-1:0] in_spec_im,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] out_re,
  output logic signed [SAMPLE_BITS-1:0] out_im,
  output logic                          out_evanescent
);

  localparam int IW  = otmu_pkg::IDX_W;
  localparam int FW  = otmu_pkg::FREQ_W;
  localparam int SB  = SAMPLE_BITS;
  localparam int PW  = SAMPLE_BITS + 33;
  localparam int SQL = otmu_pkg::SQRT_LAT;
  localparam int TRL = otmu_pkg::TRIG_LAT;
  localparam int TOTAL_LAT = 5 + SQL + 4 + TRL + 3;
  localparam int unsigned IDX_SH = 22;
  localparam logic [22:0] IDX_RCP =
    23'(((64'd1 << IDX_SH) + 64'(GRID_SIZE) - 64'd1) / GRID_SIZE);

  typedef struct packed {
    logic                       ev;
    logic [otmu_pkg::PHASE_W-1:0] fph;
    logic signed [SB-1:0]       re;
    logic signed [SB-1:0]       im;
  } sq_side_t;

  typedef struct packed {
    logic [1:0]           quad;
    logic                 swap;
    logic                 ev;
    logic signed [SB-1:0] re;
    logic signed [SB-1:0] im;
  } tr_side_t;

  // Maps an index and its grid quotient to a signed frequency
  function automatic logic signed [FW-1:0] freq_of(input logic [IW-1:0] idx,
                                                   input logic [IW-1:0] quo);
    logic [23:0]        qg;
    logic [IW-1:0]      rem;
    logic signed [13:0] rs;
    qg  = {14'd0, quo} * 24'(GRID_SIZE);
    rem = IW'({14'd0, idx} - qg);
    rs  = $signed({4'd0, rem});
    if (14'({rem, 1'b0}) < 14'(GRID_SIZE)) begin
      return FW'(rs);
    end
    return FW'(rs - $signed(14'(GRID_SIZE)));
  endfunction

  // Round half up by 2^-30 and saturate to the sample range
  function automatic logic signed [SB-1:0] round_sat(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] sh;
    logic signed [PW-1:0] maxv;
    logic signed [PW-1:0] minv;
    sh   = (v + $signed(PW'(64'd1 << 29))) >>> 30;
    maxv = $signed(PW'((64'd1 << (SB - 1)) - 64'd1));
    minv = -maxv - $signed(PW'(1));
    if (sh > maxv) begin
      return SB'(maxv);
    end
    if (sh < minv) begin
      return SB'(minv);
    end
    return SB'(sh);
  endfunction

  // Configuration registers
  logic        mode_r;
  logic [39:0] fsq_r;
  logic [62:0] ps_r;
  logic [47:0] fres_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= otmu_pkg::MODE_ANGULAR;
      fsq_r  <= '0;
      ps_r   <= '0;
      fres_r <= '0;
    end else if (cfg_we) begin
      case (otmu_pkg::cfg_reg_t'(cfg_index))
        otmu_pkg::CFG_MODE:    mode_r <= cfg_wdata[0];
        otmu_pkg::CFG_FREQ_SQ: fsq_r  <= cfg_wdata[39:0];
        otmu_pkg::CFG_PHASE:   ps_r   <= cfg_wdata;
        otmu_pkg::CFG_FRESNEL: fres_r <= cfg_wdata[47:0];
        default: ;
      endcase
    end
  end

  logic busy_r;
  always_ff @(posedge clk) begin
    busy_r <= !rst_n;
  end
  assign busy = busy_r;

  // Stage valid bits
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r;
  logic m1_vld_r, m2_vld_r, t1_vld_r, t2_vld_r;
  logic r1_vld_r, r2_vld_r, out_vld_r;
  logic sq_vld, tr_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      s5_vld_r  <= 1'b0;
      m1_vld_r  <= 1'b0;
      m2_vld_r  <= 1'b0;
      t1_vld_r  <= 1'b0;
      t2_vld_r  <= 1'b0;
      r1_vld_r  <= 1'b0;
      r2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= start && !busy_r;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= s3_vld_r;
      s5_vld_r  <= s4_vld_r;
      m1_vld_r  <= sq_vld;
      m2_vld_r  <= m1_vld_r;
      t1_vld_r  <= m2_vld_r;
      t2_vld_r  <= t1_vld_r;
      r1_vld_r  <= tr_vld;
      r2_vld_r  <= r1_vld_r;
      out_vld_r <= r2_vld_r;
    end
  end

  // S1: grid quotient of each index by reciprocal multiply
  logic [IW-1:0]        s1_row_r, s1_col_r, s1_rq_r, s1_cq_r;
  logic signed [SB-1:0] s1_re_r, s1_im_r;
  logic [32:0]          s1_rprod, s1_cprod;

  assign s1_rprod = {23'd0, in_row_index} * {10'd0, IDX_RCP};
  assign s1_cprod = {23'd0, in_col_index} * {10'd0, IDX_RCP};

  always_ff @(posedge clk) begin
    s1_row_r <= in_row_index;
    s1_col_r <= in_col_index;
    s1_rq_r  <= IW'(s1_rprod >> IDX_SH);
    s1_cq_r  <= IW'(s1_cprod >> IDX_SH);
    s1_re_r  <= in_spec_re;
    s1_im_r  <= in_spec_im;
  end

  // S2: signed frequencies
  logic signed [FW-1:0] s2_fr_r, s2_fc_r;
  logic signed [SB-1:0] s2_re_r, s2_im_r;

  always_ff @(posedge clk) begin
    s2_fr_r <= freq_of(s1_row_r, s1_rq_r);
    s2_fc_r <= freq_of(s1_col_r, s1_cq_r);
    s2_re_r <= s1_re_r;
    s2_im_r <= s1_im_r;
  end

  // S3: squared radius
  logic signed [2*FW-1:0]     s3_sqr, s3_sqc;
  logic [otmu_pkg::N2_W-1:0]  s3_n2_r;
  logic signed [SB-1:0]       s3_re_r, s3_im_r;

  assign s3_sqr = s2_fr_r * s2_fr_r;
  assign s3_sqc = s2_fc_r * s2_fc_r;

  always_ff @(posedge clk) begin
    s3_n2_r <= otmu_pkg::N2_W'(unsigned'(s3_sqr) + unsigned'(s3_sqc));
    s3_re_r <= s2_re_r;
    s3_im_r <= s2_im_r;
  end

  // S4: scale times squared radius, split in two partial products
  logic [47:0]          s4_scale;
  logic [58:0]          s4_plo_r, s4_phi_r;
  logic signed [SB-1:0] s4_re_r, s4_im_r;

  assign s4_scale = (mode_r == otmu_pkg::MODE_FRESNEL) ? fres_r : {8'd0, fsq_r};

  always_ff @(posedge clk) begin
    s4_plo_r <= {11'd0, s4_scale} * {48'd0, s3_n2_r[10:0]};
    s4_phi_r <= {11'd0, s4_scale} * {48'd0, s3_n2_r[21:11]};
    s4_re_r  <= s3_re_r;
    s4_im_r  <= s3_im_r;
  end

  // S5: angular argument and evanescent test, Fresnel phase
  logic [69:0]                  s5_prod;
  logic [47:0]                  s5_fd;
  logic [otmu_pkg::ARG_W-1:0]   s5_arg_r;
  sq_side_t                     s5_side_r;

  assign s5_prod = {11'd0, s4_plo_r} + {s4_phi_r, 11'd0};
  assign s5_fd   = {ps_r[31:0], 16'd0} - s5_prod[47:0];

  always_ff @(posedge clk) begin
    s5_arg_r     <= 41'h100_0000_0000 - s5_prod[40:0];
    s5_side_r.ev <= (mode_r == otmu_pkg::MODE_ANGULAR) &&
                    (s5_prod > 70'h100_0000_0000);
    s5_side_r.fph <= s5_fd[47:16];
    s5_side_r.re  <= s4_re_r;
    s5_side_r.im  <= s4_im_r;
  end

  // Square root of the argument, Q1.30
  logic [otmu_pkg::ROOT_W-1:0] sq_root;
  sq_side_t                    sq_line_r [SQL];

  otmu_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (s5_vld_r),
    .rad_i  ({s5_arg_r, 20'd0}),
    .vld_o  (sq_vld),
    .root_o (sq_root)
  );

  always_ff @(posedge clk) begin
    sq_line_r[0] <= s5_side_r;
    for (int i = 1; i < SQL; i++) begin
      sq_line_r[i] <= sq_line_r[i-1];
    end
  end

  // M1: phase scale times root, split at bit 32
  logic [61:0]    m1_lo_r;
  logic [29:0]    m1_hi_r;
  logic [62:0]    m1_lo;
  logic [61:0]    m1_hi;
  sq_side_t       m1_side_r;

  assign m1_lo = {31'd0, ps_r[31:0]} * {32'd0, sq_root};
  assign m1_hi = {31'd0, ps_r[62:32]} * {31'd0, sq_root};

  always_ff @(posedge clk) begin
    m1_lo_r   <= m1_lo[61:0];
    m1_hi_r   <= m1_hi[29:0];
    m1_side_r <= sq_line_r[SQL-1];
  end

  // M2: phase in turns for the selected mode
  logic [61:0]                  m2_sum;
  logic [otmu_pkg::PHASE_W-1:0] m2_ph_r;
  logic                         m2_ev_r;
  logic signed [SB-1:0]         m2_re_r, m2_im_r;

  assign m2_sum = m1_lo_r + {m1_hi_r, 32'd0};

  always_ff @(posedge clk) begin
    m2_ph_r <= (mode_r == otmu_pkg::MODE_FRESNEL) ? m1_side_r.fph : m2_sum[61:30];
    m2_ev_r <= m1_side_r.ev;
    m2_re_r <= m1_side_r.re;
    m2_im_r <= m1_side_r.im;
  end

  // T1: fold to an octant, start the radian conversion
  logic [29:0] t1_r, t1_m;
  logic        t1_swap;
  logic [47:0] t1_phi_r;
  logic [46:0] t1_plo_r;
  tr_side_t    t1_side_r;

  assign t1_r    = m2_ph_r[29:0];
  assign t1_swap = t1_r > 30'h2000_0000;
  assign t1_m    = t1_swap ? 30'(31'h4000_0000 - {1'b0, t1_r}) : t1_r;

  always_ff @(posedge clk) begin
    t1_phi_r       <= {18'd0, t1_m} * {30'd0, otmu_pkg::TWO_PI_Q32[34:17]};
    t1_plo_r       <= {17'd0, t1_m} * {30'd0, otmu_pkg::TWO_PI_Q32[16:0]};
    t1_side_r.quad <= m2_ph_r[31:30];
    t1_side_r.swap <= t1_swap;
    t1_side_r.ev   <= m2_ev_r;
    t1_side_r.re   <= m2_re_r;
    t1_side_r.im   <= m2_im_r;
  end

  // T2: octant angle in Q0.30 radians
  logic [64:0]              t2_sum;
  logic [otmu_pkg::X_W-1:0] t2_x_r;
  tr_side_t                 t2_side_r;

  assign t2_sum = {t1_phi_r, 17'd0} + {18'd0, t1_plo_r};

  always_ff @(posedge clk) begin
    t2_x_r    <= t2_sum[63:34];
    t2_side_r <= t1_side_r;
  end

  // Sine and cosine of the octant angle
  logic [otmu_pkg::CS_W-1:0] tr_cos, tr_sin;
  tr_side_t                  tr_line_r [TRL];

  otmu_trig u_trig (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (t2_vld_r),
    .x_i   (t2_x_r),
    .vld_o (tr_vld),
    .cos_o (tr_cos),
    .sin_o (tr_sin)
  );

  always_ff @(posedge clk) begin
    tr_line_r[0] <= t2_side_r;
    for (int i = 1; i < TRL; i++) begin
      tr_line_r[i] <= tr_line_r[i-1];
    end
  end

  // R1: unfold to the full circle and form the four products
  tr_side_t             r1_side;
  logic [otmu_pkg::CS_W-1:0] r1_a, r1_b;
  logic signed [31:0]   r1_c, r1_s;
  logic signed [SB+31:0] r1_rc_r, r1_is_r, r1_rs_r, r1_ic_r;
  logic                 r1_ev_r;

  assign r1_side = tr_line_r[TRL-1];
  assign r1_a = (r1_side.swap ^ r1_side.quad[0]) ? tr_sin : tr_cos;
  assign r1_b = (r1_side.swap ^ r1_side.quad[0]) ? tr_cos : tr_sin;
  assign r1_c = (r1_side.quad[0] ^ r1_side.quad[1]) ? -$signed({1'b0, r1_a})
                                                    : $signed({1'b0, r1_a});
  assign r1_s = r1_side.quad[1] ? -$signed({1'b0, r1_b}) : $signed({1'b0, r1_b});

  always_ff @(posedge clk) begin
    r1_rc_r <= r1_side.re * r1_c;
    r1_is_r <= r1_side.im * r1_s;
    r1_rs_r <= r1_side.re * r1_s;
    r1_ic_r <= r1_side.im * r1_c;
    r1_ev_r <= r1_side.ev;
  end

  // R2: complex rotation sums
  logic signed [PW-1:0] r2_vr_r, r2_vi_r;
  logic                 r2_ev_r;

  always_ff @(posedge clk) begin
    r2_vr_r <= PW'(r1_rc_r) - PW'(r1_is_r);
    r2_vi_r <= PW'(r1_rs_r) + PW'(r1_ic_r);
    r2_ev_r <= r1_ev_r;
  end

  // R3: round, saturate, zero evanescent bins
  logic signed [SB-1:0] out_re_r, out_im_r;
  logic                 out_ev_r;

  always_ff @(posedge clk) begin
    out_re_r <= r2_ev_r ? '0 : round_sat(r2_vr_r);
    out_im_r <= r2_ev_r ? '0 : round_sat(r2_vi_r);
    out_ev_r <= r2_ev_r;
  end

  assign out_valid      = out_vld_r;
  assign out_re         = out_re_r;
  assign out_im         = out_im_r;
  assign out_evanescent = out_ev_r;

  // Every accepted item comes out after the fixed pipeline depth
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##TOTAL_LAT out_valid)
    else $error("item lost in pipeline");

  // Evanescent bins carry a zero sample
  a_ev_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_evanescent) |-> (out_re == '0) && (out_im == '0))
    else $error("evanescent bin not zeroed");

  // A reset cycle leaves no result in flight
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !r2_vld_r && !s1_vld_r)
    else $error("valid bit survived reset");

endmodule
